@@ rtl/core/multi_block_bump_arena_allocator_core_macros.svh @@
// assertion helpers used by the arena allocator controller
`ifndef MULTI_BLOCK_BUMP_ARENA_ALLOCATOR_CORE_MACROS_SVH
`define MULTI_BLOCK_BUMP_ARENA_ALLOCATOR_CORE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define MBBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition in one cycle implies a condition in the next
`define MBBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mbba_pkg.sv @@
`default_nettype none

package mbba_pkg;

  localparam int FRAME_SLOTS    = 4;
  localparam int MAX_BLOCKS     = 16;
  localparam int DEPTH          = FRAME_SLOTS * MAX_BLOCKS;
  localparam int SLOT_W         = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int IDX_W          = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W          = $clog2(MAX_BLOCKS + 1);
  localparam int ADDR_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int FSLOT_W        = 2;
  localparam int SIZE_W         = 24;
  localparam int ALIGN_W        = 5;
  localparam int LEN_W          = 26;
  localparam int OFF_W          = 25;
  localparam int BIDX_W         = 4;
  localparam int ALM1_W         = 16;
  localparam int SUM_W          = 25;
  localparam int ALIGN_LOG2_MAX = 16;
  localparam logic [LEN_W-1:0] MIN_BLOCK_RESET = LEN_W'(65536);

  typedef enum logic [1:0] {
    ST_PLACED     = 2'd0,
    ST_NEW_BLOCK  = 2'd1,
    ST_FULL       = 2'd2,
    ST_RESET_DONE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_RESP
  } state_e;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_RESET = 1'b1
  } func_e;

  // write and clear commands towards the block store
  typedef struct packed {
    logic              used_we;
    logic              cap_we;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  used;
    logic [LEN_W-1:0]  cap;
    logic              clr;
    logic [SLOT_W-1:0] clr_slot;
  } mbba_wr_t;

  typedef struct packed {
    status_e           status;
    logic [BIDX_W-1:0] block_index;
    logic [OFF_W-1:0]  byte_offset;
    logic [LEN_W-1:0]  new_block_bytes;
  } mbba_res_t;

  function automatic logic [ADDR_W-1:0] blk_addr(input logic [SLOT_W-1:0] slot,
                                                 input logic [IDX_W-1:0]  idx);
    blk_addr = ADDR_W'(slot) * ADDR_W'(MAX_BLOCKS) + ADDR_W'(idx);
  endfunction

  // smallest power of two not below v, v is at least two
  function automatic logic [LEN_W-1:0] next_pow2(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] p;
    p = v - SUM_W'(1);
    p = p | (p >> 1);
    p = p | (p >> 2);
    p = p | (p >> 4);
    p = p | (p >> 8);
    p = p | (p >> 16);
    next_pow2 = LEN_W'(p) + LEN_W'(1);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/mbba_req_if.sv @@
`default_nettype none

interface mbba_req_if;
  import mbba_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic [FSLOT_W-1:0] frame_slot;
  logic [SIZE_W-1:0]  req_bytes;
  logic [ALIGN_W-1:0] align_log2;

  modport source (output valid, func, frame_slot, req_bytes, align_log2, input ready);
  modport sink   (input valid, func, frame_slot, req_bytes, align_log2, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mbba_rsp_if.sv @@
`default_nettype none

interface mbba_rsp_if;
  import mbba_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [BIDX_W-1:0] block_index;
  logic [OFF_W-1:0]  byte_offset;
  logic [LEN_W-1:0]  new_block_bytes;

  modport source (output valid, status, block_index, byte_offset, new_block_bytes,
                  input ready);
  modport sink   (input valid, status, block_index, byte_offset, new_block_bytes,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/multi_block_bump_arena_allocator_core.sv @@
// Bump allocator over per-slot block lists, one transaction at a time. A reset request
// is latched into the result register and moves to the output register once that
// register can take it. An allocation probes blocks from the slot cursor on and retires
// each one that does not fit, because the used and capacity memories have one read port
// and one block is probed per cycle. A new transaction is accepted in the cycle after
// the result moves to the output register. Used counts are cleared through per-entry
// valid bits, so there is no clearing pass after reset. min_block_bytes is written
// through cfg_we_i and cfg_wdata_i; the user must write it only while the block is idle,
// which the block itself does not enforce.
`default_nettype none

module multi_block_bump_arena_allocator_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  mbba_req_if.sink                        req_i,
  mbba_rsp_if.source                      rsp_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [mbba_pkg::LEN_W-1:0] cfg_wdata_i
);
  import mbba_pkg::*;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  mbba_wr_t          wr;
  logic [LEN_W-1:0]  used_rd;
  logic [LEN_W-1:0]  cap_rd;
  logic              res_valid;
  logic              res_ready;
  mbba_res_t         res;
  logic              out_valid_q;
  mbba_res_t         out_q;

  mbba_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .used_rd_o (used_rd),
    .cap_rd_o  (cap_rd)
  );

  mbba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .wr_o        (wr),
    .used_rd_i   (used_rd),
    .cap_rd_i    (cap_rd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register, refilled in the cycle the previous result is taken
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_q.status;
  assign rsp_o.block_index     = out_q.block_index;
  assign rsp_o.byte_offset     = out_q.byte_offset;
  assign rsp_o.new_block_bytes = out_q.new_block_bytes;

endmodule

`default_nettype wire

@@ rtl/core/mbba_store.sv @@
`default_nettype none

module mbba_store (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       rd_en_i,
  input  wire logic [mbba_pkg::ADDR_W-1:0] rd_addr_i,
  input  wire mbba_pkg::mbba_wr_t         wr_i,
  output logic [mbba_pkg::LEN_W-1:0]      used_rd_o,
  output logic [mbba_pkg::LEN_W-1:0]      cap_rd_o
);
  import mbba_pkg::*;

  logic [LEN_W-1:0] used_mem [DEPTH];
  logic [LEN_W-1:0] cap_mem  [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic             vld_rd_q;
  logic [LEN_W-1:0] used_rd_q;
  logic [LEN_W-1:0] cap_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.used_we) begin
      used_mem[wr_i.addr] <= wr_i.used;
    end
    if (wr_i.cap_we) begin
      cap_mem[wr_i.addr] <= wr_i.cap;
    end
    if (rd_en_i) begin
      used_rd_q <= used_mem[rd_addr_i];
      cap_rd_q  <= cap_mem[rd_addr_i];
    end
  end

  // used counts read as zero until written since reset or the slot was reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (wr_i.clr) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (SLOT_W'(i / MAX_BLOCKS) == wr_i.clr_slot) begin
            vld_q[i] <= 1'b0;
          end
        end
      end else if (wr_i.used_we) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        vld_rd_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign used_rd_o = vld_rd_q ? used_rd_q : '0;
  assign cap_rd_o  = cap_rd_q;

endmodule

`default_nettype wire

@@ rtl/core/mbba_ctrl.sv @@
`default_nettype none

`include "multi_block_bump_arena_allocator_core_macros.svh"

module mbba_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  mbba_req_if.sink                         req_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [mbba_pkg::LEN_W-1:0]  cfg_wdata_i,
  output logic                             rd_en_o,
  output logic [mbba_pkg::ADDR_W-1:0]      rd_addr_o,
  output mbba_pkg::mbba_wr_t               wr_o,
  input  wire logic [mbba_pkg::LEN_W-1:0]  used_rd_i,
  input  wire logic [mbba_pkg::LEN_W-1:0]  cap_rd_i,
  output logic                             res_valid_o,
  input  wire logic                        res_ready_i,
  output mbba_pkg::mbba_res_t              res_o
);
  import mbba_pkg::*;

  state_e             state_q, state_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [SIZE_W-1:0]  size_q, size_d;
  logic [ALM1_W-1:0]  alm1_q, alm1_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  mbba_res_t          res_q, res_d;
  logic [CNT_W-1:0]   cursor_q [FRAME_SLOTS];
  logic [CNT_W-1:0]   cursor_d [FRAME_SLOTS];
  logic [CNT_W-1:0]   count_q  [FRAME_SLOTS];
  logic [CNT_W-1:0]   count_d  [FRAME_SLOTS];
  logic [LEN_W-1:0]   min_blk_q;

  logic [SLOT_W-1:0]  in_slot;
  logic [SIZE_W-1:0]  in_size;
  logic [ALIGN_W-1:0] in_lg;
  logic [ALM1_W:0]    in_align;
  logic [CNT_W-1:0]   cur;
  logic [CNT_W-1:0]   cur_nxt;
  logic [CNT_W-1:0]   cnt;
  logic [LEN_W:0]     off;
  logic [LEN_W+1:0]   end_off;
  logic               fit;
  logic [LEN_W-1:0]   pow_blk;
  logic [LEN_W-1:0]   new_blk;

  assign in_slot  = SLOT_W'(req_i.frame_slot % FRAME_SLOTS);
  assign in_size  = (req_i.req_bytes == '0) ? SIZE_W'(1) : req_i.req_bytes;
  assign in_lg    = (req_i.align_log2 > ALIGN_W'(ALIGN_LOG2_MAX)) ?
                    ALIGN_W'(ALIGN_LOG2_MAX) : req_i.align_log2;
  assign in_align = (ALM1_W + 1)'(1) << in_lg;

  assign cur     = cursor_q[slot_q];
  assign cur_nxt = cur + CNT_W'(1);
  assign cnt     = count_q[slot_q];

  // align the used count up, then check the request against the capacity
  assign off     = ((LEN_W + 1)'(used_rd_i) + (LEN_W + 1)'(alm1_q)) & ~((LEN_W + 1)'(alm1_q));
  assign end_off = (LEN_W + 2)'(off) + (LEN_W + 2)'(size_q);
  assign fit     = end_off <= (LEN_W + 2)'(cap_rd_i);

  assign pow_blk = next_pow2(sum_q);
  assign new_blk = (min_blk_q > pow_blk) ? min_blk_q : pow_blk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      slot_q    <= '0;
      min_blk_q <= MIN_BLOCK_RESET;
      for (int s = 0; s < FRAME_SLOTS; s++) begin
        cursor_q[s] <= '0;
        count_q[s]  <= '0;
      end
    end else begin
      state_q  <= state_d;
      slot_q   <= slot_d;
      cursor_q <= cursor_d;
      count_q  <= count_d;
      if (cfg_we_i) begin
        min_blk_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    size_q <= size_d;
    alm1_q <= alm1_d;
    sum_q  <= sum_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    size_d      = size_q;
    alm1_d      = alm1_q;
    sum_d       = sum_q;
    res_d       = res_q;
    cursor_d    = cursor_q;
    count_d     = count_q;
    req_i.ready = 1'b0;
    rd_en_o     = 1'b0;
    rd_addr_o   = blk_addr(slot_q, cur_nxt[IDX_W-1:0]);
    wr_o        = '0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        rd_addr_o   = blk_addr(in_slot, cursor_q[in_slot][IDX_W-1:0]);
        if (req_i.valid) begin
          slot_d = in_slot;
          size_d = in_size;
          alm1_d = ALM1_W'(in_align - (ALM1_W + 1)'(1));
          sum_d  = SUM_W'(in_size) + SUM_W'(in_align);
          if (func_e'(req_i.func) == FUNC_RESET) begin
            wr_o.clr          = 1'b1;
            wr_o.clr_slot     = in_slot;
            cursor_d[in_slot] = '0;
            res_d             = '0;
            res_d.status      = ST_RESET_DONE;
            state_d           = S_RESP;
          end else begin
            rd_en_o = 1'b1;
            state_d = S_EVAL;
          end
        end
      end

      S_EVAL: begin
        wr_o.addr = blk_addr(slot_q, cur[IDX_W-1:0]);
        if (cur < cnt) begin
          if (fit) begin
            wr_o.used_we      = 1'b1;
            wr_o.used         = end_off[LEN_W-1:0];
            res_d.status      = ST_PLACED;
            res_d.block_index = cur[BIDX_W-1:0];
            res_d.byte_offset = off[OFF_W-1:0];
            res_d.new_block_bytes = '0;
            state_d           = S_RESP;
          end else begin
            // retire this block and probe the next one
            cursor_d[slot_q] = cur_nxt;
            rd_en_o          = 1'b1;
          end
        end else if (cnt >= CNT_W'(MAX_BLOCKS)) begin
          res_d        = '0;
          res_d.status = ST_FULL;
          state_d      = S_RESP;
        end else begin
          wr_o.addr         = blk_addr(slot_q, cnt[IDX_W-1:0]);
          wr_o.used_we      = 1'b1;
          wr_o.used         = LEN_W'(size_q);
          wr_o.cap_we       = 1'b1;
          wr_o.cap          = new_blk;
          count_d[slot_q]   = cnt + CNT_W'(1);
          cursor_d[slot_q]  = cnt;
          res_d.status      = ST_NEW_BLOCK;
          res_d.block_index = cnt[BIDX_W-1:0];
          res_d.byte_offset = '0;
          res_d.new_block_bytes = new_blk;
          state_d           = S_RESP;
        end
      end

      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  `MBBA_ASSERT(a_cursor_le_count, cursor_q[slot_q] <= count_q[slot_q], "cursor beyond count")
  `MBBA_ASSERT(a_count_le_max, count_q[slot_q] <= CNT_W'(MAX_BLOCKS), "block count beyond table")
  `MBBA_ASSERT(a_wr_in_eval, (wr_o.used_we || wr_o.cap_we) |-> state_q == S_EVAL, "stray write")
  `MBBA_ASSERT_NEXT(a_resp_hold, (state_q == S_RESP) && !res_ready_i, state_q == S_RESP, "dropped")

endmodule

`default_nettype wire
